/* sv/sstc_pkg.sv */
// Shared types and constants of the sum-score / target correlation core.
// No dependencies; every other file of the block but sstc_mul imports it.
package sstc_pkg;

  localparam int ITEM_W      = 8;
  localparam int NUM_ITEMS   = 8;
  localparam int MAX_ITEMS   = 8;
  localparam logic [ITEM_W-1:0] MISSING_ITEM = 8'd255;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int K_W         = 4;

  localparam int TARGET_W    = 24;
  localparam int CORR_W      = 16;
  localparam int ROWS_W      = 17;

  localparam int ROWSUM_W    = 11;
  localparam int PRESENT_W   = 4;
  localparam int SCALED_W    = ROWSUM_W + K_W;
  localparam int DVD_W       = 24;
  localparam int DVS_W       = 5;
  localparam int STEP_W      = 5;
  localparam int SCORE_W     = 20;

  localparam int SQS_W       = 2 * SCORE_W;
  localparam int SQT_W       = 2 * TARGET_W;
  localparam int PR_W        = SCORE_W + TARGET_W + 1;

  localparam int SS_W        = 37;
  localparam int SQQ_W       = 55;
  localparam int ST_W        = 41;
  localparam int STT_W       = 62;
  localparam int SP_W        = 62;
  localparam int WIDE_W      = 192;
  localparam int LIM_SHIFT   = 30;
  localparam int BIT_W       = 4;
  localparam int TOP_TRY_BIT = 14;

  localparam logic [CORR_W-1:0] Q_FULL_SCALE = 16'h8000;
  localparam logic [CORR_W-1:0] Q_POS_MAX    = 16'h7FFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ITEM_COUNT = 4'd0,
    REG_NA_REMOVE  = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [ITEM_W-1:0]          item_0;
    logic [ITEM_W-1:0]          item_1;
    logic [ITEM_W-1:0]          item_2;
    logic [ITEM_W-1:0]          item_3;
    logic [ITEM_W-1:0]          item_4;
    logic [ITEM_W-1:0]          item_5;
    logic [ITEM_W-1:0]          item_6;
    logic [ITEM_W-1:0]          item_7;
    logic signed [TARGET_W-1:0] target_value;
    logic                       target_missing;
    logic                       row_last;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic                     correlation_valid;
    logic [ROWS_W-1:0]        rows_used;
  } out_item_t;

  typedef struct packed {
    logic [DVD_W-1:0]           dividend;
    logic [DVS_W-1:0]           divisor;
    logic                       take;
    logic signed [TARGET_W-1:0] target;
    logic                       last;
  } row_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_ACC,
    ST_CHK, ST_A1, ST_A2, ST_B1, ST_B2, ST_C1, ST_C2,
    ST_AB, ST_CC, ST_TRY, ST_CMP, ST_OUT
  } back_state_t;

endpackage

/* sv/sstc_front.sv */
// Front end: accepts rows, sums the present items and classifies each row.
// Depends on sstc_pkg.
module sstc_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sstc_pkg::in_item_t            in_data,
  input  logic [sstc_pkg::K_W-1:0]      item_count,
  input  logic                          na_remove,
  input  logic                          q_full,
  output logic                          push,
  output sstc_pkg::row_entry_t          push_entry
);
  import sstc_pkg::*;

  logic [ITEM_W-1:0]    items [NUM_ITEMS];
  logic [K_W-1:0]       k;
  logic [ROWSUM_W-1:0]  row_sum;
  logic [PRESENT_W-1:0] present;
  logic [SCALED_W-1:0]  scaled;

  assign items = '{in_data.item_0, in_data.item_1, in_data.item_2, in_data.item_3,
                   in_data.item_4, in_data.item_5, in_data.item_6, in_data.item_7};

  always_comb begin
    if (item_count == '0) begin
      k = K_W'(1);
    end else if (item_count > K_W'(MAX_ITEMS)) begin
      k = K_W'(MAX_ITEMS);
    end else begin
      k = item_count;
    end
  end

  always_comb begin
    row_sum = '0;
    present = '0;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (K_W'(i) < k && items[i] != MISSING_ITEM) begin
        row_sum = row_sum + ROWSUM_W'(items[i]);
        present = present + PRESENT_W'(1);
      end
    end
  end

  assign scaled = SCALED_W'(row_sum) * SCALED_W'(k);

  always_comb begin
    push_entry.dividend = {scaled, {(DVD_W - SCALED_W){1'b0}}} + DVD_W'(present);
    push_entry.divisor  = {present, 1'b0};
    push_entry.take     = !in_data.target_missing &&
                          (na_remove ? (present != '0) : (present == k));
    push_entry.target   = in_data.target_value;
    push_entry.last     = in_data.row_last;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

endmodule

/* sv/sstc_queue.sv */
// Short first-in first-out queue of classified rows between front and back.
// Depends on sstc_pkg.
module sstc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sstc_pkg::row_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output sstc_pkg::row_entry_t head,
  output logic                 empty
);
  import sstc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  row_entry_t     slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* sv/sstc_mul.sv */
// Shift-and-add multiplier, one multiplier bit a cycle, stops once y runs out.
// No dependencies; product is truncated to W bits.
module sstc_mul #(
  parameter int W = 192
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic         busy,
  output logic [W-1:0] prod
);

  logic [W-1:0] xr;
  logic [W-1:0] yr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && yr == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      yr   <= y;
      prod <= '0;
    end else if (busy && yr != '0) begin
      if (yr[0]) begin
        prod <= prod + xr;
      end
      xr <= {xr[W-2:0], 1'b0};
      yr <= {1'b0, yr[W-1:1]};
    end
  end

endmodule

/* sv/sstc_back.sv */
// Back end: scores rows, builds the five sums and the row count, and on the last
// row of a set works out the correlation. Depends on sstc_pkg and sstc_mul.
module sstc_back #(
  parameter int MAX_ROWS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  sstc_pkg::row_entry_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sstc_pkg::out_item_t  out_data
);
  import sstc_pkg::*;

  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  back_state_t              state;
  back_state_t              state_next;
  row_entry_t               ent;
  logic [DVS_W-1:0]         rem;
  logic [DVD_W-1:0]         dq;
  logic [STEP_W-1:0]        step;
  logic [DVS_W:0]           trial;
  logic [DVS_W:0]           diff;
  logic [SCORE_W-1:0]       score;

  logic [SQS_W-1:0]         sq_s;
  logic [SQT_W-1:0]         sq_t;
  logic signed [PR_W-1:0]   pr;

  logic [SS_W-1:0]          ss_sum;
  logic [SQQ_W-1:0]         sqq_sum;
  logic signed [ST_W-1:0]   st_sum;
  logic [STT_W-1:0]         stt_sum;
  logic signed [SP_W-1:0]   sp_sum;
  logic [CNT_W-1:0]         cnt;
  logic [ST_W-1:0]          st_mag;
  logic [SP_W-1:0]          sp_mag;

  logic [WIDE_W-1:0]        pw;
  logic [WIDE_W-1:0]        a_v;
  logic [WIDE_W-1:0]        b_v;
  logic [WIDE_W-1:0]        c_v;
  logic [WIDE_W-1:0]        ab;
  logic [WIDE_W-1:0]        lim;
  logic                     c_neg;
  logic                     p_neg;
  logic [CORR_W-1:0]        q;
  logic [BIT_W-1:0]         bitn;
  logic [CORR_W-1:0]        cand;
  logic [2*CORR_W-1:0]      cand_sq;
  logic                     fval;
  logic [CORR_W-1:0]        corr;

  logic                     mul_start;
  logic [WIDE_W-1:0]        mul_x;
  logic [WIDE_W-1:0]        mul_y;
  logic                     mul_busy;
  logic [WIDE_W-1:0]        prod;
  logic                     out_load;

  sstc_mul #(.W(WIDE_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .busy  (mul_busy),
    .prod  (prod)
  );

  assign trial   = {rem, dq[DVD_W-1]};
  assign diff    = trial - {1'b0, ent.divisor};
  assign score   = dq[SCORE_W-1:0];
  assign st_mag  = st_sum[ST_W-1] ? ST_W'(-st_sum) : ST_W'(st_sum);
  assign sp_mag  = sp_sum[SP_W-1] ? SP_W'(-sp_sum) : SP_W'(sp_sum);
  assign cand    = q | (CORR_W'(1) << bitn);
  assign cand_sq = {{CORR_W{1'b0}}, cand} * {{CORR_W{1'b0}}, cand};

  always_comb begin
    if (!fval) begin
      corr = '0;
    end else if (c_neg) begin
      corr = -q;
    end else if (q > Q_POS_MAX) begin
      corr = Q_POS_MAX;
    end else begin
      corr = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mul_start  = 1'b0;
    mul_x      = '0;
    mul_y      = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.take && cnt < CNT_W'(MAX_ROWS)) begin
            state_next = ST_DIV;
          end else if (head.last) begin
            state_next = ST_CHK;
          end
        end
      end
      ST_DIV: begin
        if (step == STEP_W'(DVD_W - 1)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = ent.last ? ST_CHK : ST_IDLE;
      ST_CHK: begin
        if (cnt < CNT_W'(2)) begin
          state_next = ST_OUT;
        end else begin
          mul_start  = 1'b1;
          mul_x      = WIDE_W'(sqq_sum);
          mul_y      = WIDE_W'(cnt);
          state_next = ST_A1;
        end
      end
      ST_A1: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          mul_x      = WIDE_W'(ss_sum);
          mul_y      = WIDE_W'(ss_sum);
          state_next = ST_A2;
        end
      end
      ST_A2: begin
        if (!mul_busy) begin
          if (pw <= prod) begin
            state_next = ST_OUT;
          end else begin
            mul_start  = 1'b1;
            mul_x      = WIDE_W'(stt_sum);
            mul_y      = WIDE_W'(cnt);
            state_next = ST_B1;
          end
        end
      end
      ST_B1: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          mul_x      = WIDE_W'(st_mag);
          mul_y      = WIDE_W'(st_mag);
          state_next = ST_B2;
        end
      end
      ST_B2: begin
        if (!mul_busy) begin
          if (pw <= prod) begin
            state_next = ST_OUT;
          end else begin
            mul_start  = 1'b1;
            mul_x      = WIDE_W'(sp_mag);
            mul_y      = WIDE_W'(cnt);
            state_next = ST_C1;
          end
        end
      end
      ST_C1: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          mul_x      = WIDE_W'(st_mag);
          mul_y      = WIDE_W'(ss_sum);
          state_next = ST_C2;
        end
      end
      ST_C2: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          mul_x      = b_v;
          mul_y      = a_v;
          state_next = ST_AB;
        end
      end
      ST_AB: begin
        if (!mul_busy) begin
          mul_start  = 1'b1;
          mul_x      = c_v;
          mul_y      = c_v;
          state_next = ST_CC;
        end
      end
      ST_CC: begin
        if (!mul_busy) begin
          state_next = (ab <= prod) ? ST_OUT : ST_TRY;
        end
      end
      ST_TRY: begin
        mul_start  = 1'b1;
        mul_x      = ab;
        mul_y      = WIDE_W'(cand_sq);
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!mul_busy) begin
          state_next = (bitn == '0) ? ST_OUT : ST_TRY;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sums and handshake flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ss_sum    <= '0;
      sqq_sum   <= '0;
      st_sum    <= '0;
      stt_sum   <= '0;
      sp_sum    <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_ACC) begin
        ss_sum  <= ss_sum + SS_W'(score);
        sqq_sum <= sqq_sum + SQQ_W'(sq_s);
        st_sum  <= st_sum + ST_W'(ent.target);
        stt_sum <= stt_sum + STT_W'(sq_t);
        sp_sum  <= sp_sum + SP_W'(pr);
        cnt     <= cnt + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
        ss_sum    <= '0;
        sqq_sum   <= '0;
        st_sum    <= '0;
        stt_sum   <= '0;
        sp_sum    <= '0;
        cnt       <= '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the divider and the correlation sequence
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          ent  <= head;
          rem  <= '0;
          dq   <= head.dividend;
          step <= '0;
          fval <= 1'b0;
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, ent.divisor}) begin
          rem <= diff[DVS_W-1:0];
          dq  <= {dq[DVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[DVS_W-1:0];
          dq  <= {dq[DVD_W-2:0], 1'b0};
        end
        step <= step + STEP_W'(1);
      end
      ST_MUL: begin
        sq_s <= SQS_W'(score) * SQS_W'(score);
        sq_t <= SQT_W'(ent.target) * SQT_W'(ent.target);
        pr   <= PR_W'($signed({1'b0, score})) * PR_W'(ent.target);
      end
      ST_A1, ST_B1: begin
        if (!mul_busy) begin
          pw <= prod;
        end
      end
      ST_A2: begin
        if (!mul_busy) begin
          a_v <= pw - prod;
        end
      end
      ST_B2: begin
        if (!mul_busy) begin
          b_v <= pw - prod;
        end
      end
      ST_C1: begin
        if (!mul_busy) begin
          pw    <= prod;
          p_neg <= sp_sum[SP_W-1];
        end
      end
      ST_C2: begin
        if (!mul_busy) begin
          if (p_neg != st_sum[ST_W-1]) begin
            c_v   <= pw + prod;
            c_neg <= p_neg;
          end else if (pw >= prod) begin
            c_v   <= pw - prod;
            c_neg <= p_neg;
          end else begin
            c_v   <= prod - pw;
            c_neg <= !p_neg;
          end
        end
      end
      ST_AB: begin
        if (!mul_busy) begin
          ab <= prod;
        end
      end
      ST_CC: begin
        if (!mul_busy) begin
          lim <= prod << LIM_SHIFT;
          if (ab <= prod) begin
            q    <= Q_FULL_SCALE;
            fval <= 1'b1;
          end else begin
            q    <= '0;
            bitn <= BIT_W'(TOP_TRY_BIT);
          end
        end
      end
      ST_CMP: begin
        if (!mul_busy) begin
          if (prod <= lim) begin
            q <= cand;
          end
          if (bitn == '0) begin
            fval <= 1'b1;
          end else begin
            bitn <= bitn - BIT_W'(1);
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_data.correlation       <= corr;
          out_data.correlation_valid <= fval;
          out_data.rows_used         <= ROWS_W'(cnt);
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/sum_score_target_correlation_core.sv */
// Streaming sum-score / target correlation. Rows enter on in_valid/in_stall; the
// front end sums the used item bytes (255 = missing), decides whether the row can
// count and parks it in a short queue. The back end takes one row at a time: a
// counted row is popped, scored by a 24-step restoring divide, then goes through
// a multiply state and an accumulate state; a skipped row is only popped. The
// sustained rate is set by the one-bit-a-cycle score divider. The row marked
// last also starts the closing sequence, which runs on one shared shift-and-add
// multiplier, one multiplier bit a cycle: eight wide products and fifteen trial
// products for the bit-by-bit search of |r|. The sequence is cut short when
// fewer than two rows were counted or when a variance is not positive. Rows keep
// arriving into the queue meanwhile, until it is full. The result sits in an
// output register until taken. Write configuration only while the block is idle;
// cfg_ready is always high. No clearing pass follows reset.
module sum_score_target_correlation_core #(
  parameter int MAX_ROWS    = 65536,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sstc_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sstc_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sstc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sstc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sstc_pkg::*;

  logic [K_W-1:0] item_count;
  logic           na_remove;
  logic           push;
  row_entry_t     push_entry;
  logic           q_full;
  logic           q_empty;
  logic           pop;
  row_entry_t     head;

  // Configuration: always ready, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= K_W'(MAX_ITEMS);
      na_remove  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ITEM_COUNT) begin
        item_count <= cfg_data[K_W-1:0];
      end else if (cfg_index == REG_NA_REMOVE) begin
        na_remove <= cfg_data[0];
      end
    end
  end

  // Classify each row on entry
  sstc_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_count (item_count),
    .na_remove  (na_remove),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Hold classified rows until the back end is free
  sstc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  // Score, accumulate and close each set
  sstc_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
